// ----- src/blake2b_hash_engine_unit_macros.svh -----
// Assertion helpers for the hash engine
`ifndef BLAKE2B_HASH_ENGINE_UNIT_MACROS_SVH
`define BLAKE2B_HASH_ENGINE_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define B2B_ASSERT_IMP(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`define B2B_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/b2b_pkg.sv -----
`default_nettype none
package b2b_pkg;
  localparam int unsigned MsgWords = 16;
  localparam int unsigned Rounds = 12;
  localparam logic [6:0] DigestReset = 7'd64;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15},
    '{4'd14,4'd10,4'd4,4'd8,4'd9,4'd15,4'd13,4'd6,4'd1,4'd12,4'd0,4'd2,4'd11,4'd7,4'd5,4'd3},
    '{4'd11,4'd8,4'd12,4'd0,4'd5,4'd2,4'd15,4'd13,4'd10,4'd14,4'd3,4'd6,4'd7,4'd1,4'd9,4'd4},
    '{4'd7,4'd9,4'd3,4'd1,4'd13,4'd12,4'd11,4'd14,4'd2,4'd6,4'd5,4'd10,4'd4,4'd0,4'd15,4'd8},
    '{4'd9,4'd0,4'd5,4'd7,4'd2,4'd4,4'd10,4'd15,4'd14,4'd1,4'd11,4'd12,4'd6,4'd8,4'd3,4'd13},
    '{4'd2,4'd12,4'd6,4'd10,4'd0,4'd11,4'd8,4'd3,4'd4,4'd13,4'd7,4'd5,4'd15,4'd14,4'd1,4'd9},
    '{4'd12,4'd5,4'd1,4'd15,4'd14,4'd13,4'd4,4'd10,4'd0,4'd7,4'd6,4'd3,4'd9,4'd2,4'd8,4'd11},
    '{4'd13,4'd11,4'd7,4'd14,4'd12,4'd1,4'd3,4'd9,4'd5,4'd0,4'd15,4'd4,4'd8,4'd6,4'd2,4'd10},
    '{4'd6,4'd15,4'd14,4'd9,4'd11,4'd3,4'd0,4'd8,4'd12,4'd2,4'd13,4'd7,4'd1,4'd4,4'd10,4'd5},
    '{4'd10,4'd2,4'd8,4'd4,4'd7,4'd6,4'd1,4'd5,4'd15,4'd11,4'd9,4'd14,4'd3,4'd12,4'd13,4'd0}};

  // Effective digest length: 0 reads as 1, above 64 reads as 64
  function automatic logic [6:0] used_len(input logic [6:0] l);
    logic [6:0] r;
    r = l;
    if (l == 7'd0) r = 7'd1;
    else if (l > 7'd64) r = 7'd64;
    return r;
  endfunction

  // Half of G: the two data paths differ only in rotation amounts
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } quad_t;

  function automatic quad_t half_g(input quad_t q, input logic [63:0] m, input logic second);
    quad_t r;
    logic [63:0] t;
    r.a = q.a + q.b + m;
    t = q.d ^ r.a;
    r.d = second ? {t[15:0], t[63:16]} : {t[31:0], t[63:32]};
    r.c = q.c + r.d;
    t = q.b ^ r.c;
    r.b = second ? {t[62:0], t[63]} : {t[23:0], t[63:24]};
    return r;
  endfunction

  typedef struct packed {
    logic        start;
    logic        final_blk;
    logic [127:0] counter;
    logic [7:0]  fill;
  } comp_req_t;
endpackage
`default_nettype wire

// ----- src/b2b_compress.sv -----
`default_nettype none
// Compression core: v and m live in small memories; one half-G per cycle.
module b2b_compress
  import b2b_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire comp_req_t    req_i,
  input  wire logic [511:0] h_i,
  // message buffer read port
  output logic [3:0]        m_addr_o,
  input  wire logic [63:0]  m_data_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [511:0]      h_o
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_READ = 4'b0010, S_MIX = 4'b0100, S_FIN = 4'b1000
  } cst_e;

  cst_e        state_q, state_d;
  logic [3:0]  round_q;
  logic [3:0]  step_q;     // 8 G calls x 2 halves
  logic [7:0]  fill_q;
  logic [63:0] v_q [16];
  logic [511:0] h_q;

  logic [3:0] ia, ib, ic, id;
  logic [3:0] sel;
  logic [3:0] rperm;
  quad_t q_in, q_out;
  logic [63:0] mval;
  logic [3:0] m_idx;

  always_comb begin
    unique case (step_q[3:1])
      3'd0: begin ia=4'd0; ib=4'd4; ic=4'd8;  id=4'd12; end
      3'd1: begin ia=4'd1; ib=4'd5; ic=4'd9;  id=4'd13; end
      3'd2: begin ia=4'd2; ib=4'd6; ic=4'd10; id=4'd14; end
      3'd3: begin ia=4'd3; ib=4'd7; ic=4'd11; id=4'd15; end
      3'd4: begin ia=4'd0; ib=4'd5; ic=4'd10; id=4'd15; end
      3'd5: begin ia=4'd1; ib=4'd6; ic=4'd11; id=4'd12; end
      3'd6: begin ia=4'd2; ib=4'd7; ic=4'd8;  id=4'd13; end
      default: begin ia=4'd3; ib=4'd4; ic=4'd9; id=4'd14; end
    endcase
  end

  // message index needed for the next half step, read in the cycle before that step
  logic [3:0] nstep, nround;
  always_comb begin
    nstep = step_q + 4'd1;
    nround = (step_q == 4'd15) ? round_q + 4'd1 : round_q;
    if (state_q == S_READ) begin
      nstep = 4'd0;
      nround = 4'd0;
    end
    rperm = (nround >= 4'd10) ? nround - 4'd10 : nround;
    sel = SIGMA[rperm][nstep];
    m_idx = sel;
  end
  assign m_addr_o = m_idx;

  // padding: words past the fill read as zero
  logic [3:0] m_idx_q;
  always_ff @(posedge clk_i) m_idx_q <= m_idx;
  assign mval = ({1'b0, m_idx_q, 3'b000} < fill_q) ? m_data_i : 64'd0;

  assign q_in = '{a: v_q[ia], b: v_q[ib], c: v_q[ic], d: v_q[id]};
  assign q_out = half_g(q_in, mval, step_q[0]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_i.start) state_d = S_READ;
      S_READ: state_d = S_MIX;
      S_MIX:  if (step_q == 4'd15 && round_q == 4'(Rounds - 1)) state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      round_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_READ) begin
        round_q <= '0;
        step_q  <= '0;
      end else if (state_q == S_MIX) begin
        step_q <= step_q + 4'd1;
        if (step_q == 4'd15) round_q <= round_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.start) begin
      fill_q  <= req_i.fill;
      h_q     <= h_i;
      for (int i = 0; i < 8; i++) v_q[i] <= h_i[64*i +: 64];
      v_q[8]  <= IV[0];
      v_q[9]  <= IV[1];
      v_q[10] <= IV[2];
      v_q[11] <= IV[3];
      v_q[12] <= IV[4] ^ req_i.counter[63:0];
      v_q[13] <= IV[5] ^ req_i.counter[127:64];
      v_q[14] <= req_i.final_blk ? ~IV[6] : IV[6];
      v_q[15] <= IV[7];
    end else if (state_q == S_MIX) begin
      v_q[ia] <= q_out.a;
      v_q[ib] <= q_out.b;
      v_q[ic] <= q_out.c;
      v_q[id] <= q_out.d;
    end else if (state_q == S_FIN) begin
      for (int i = 0; i < 8; i++) h_q[64*i +: 64] <= h_q[64*i +: 64] ^ v_q[i] ^ v_q[i+8];
    end
  end

  assign busy_o = (state_q != S_IDLE);
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= (state_q == S_FIN);
  end
  assign done_o = done_q;
  assign h_o = h_q;
endmodule
`default_nettype wire

// ----- src/blake2b_hash_engine_unit.sv -----
// Channel   | Direction | Handshake       | Payload
// message   | in        | valid / stall   | message_word, byte_count, last_word
// digest    | out       | valid / stall   | digest_word, word_index, valid_bytes, last_result
// config    | in        | valid / ready   | digest_bytes
// A compression runs through start, read, 12 rounds x 16 half-G steps, fold, done.
// A non-last word is stored into the buffer, or, when the buffer is full, first compresses it.
// A last word adds the final compression, after compressing a full buffer when the word brings bytes.
// Digest words then leave one per cycle while the output is not stalled.
// Reset is asynchronous, active low; the engine returns to the empty-message state.
`default_nettype none
module blake2b_hash_engine_unit
  import b2b_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] message_word_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic        last_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic [3:0]       valid_bytes_o,
  output logic             last_result_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  digest_bytes_i
);
  typedef enum logic [3:0] {
    T_IDLE = 4'b0001, T_PRE = 4'b0010, T_FINAL = 4'b0100, T_OUT = 4'b1000
  } top_e;

  top_e state_q, state_d;
  logic [6:0]   len_q;
  logic [511:0] h_q;
  logic [127:0] cnt_q;
  logic [7:0]   fill_q;
  logic [63:0]  buf_mem [16];
  logic [63:0]  buf_rd_q;
  logic         pend_last_q;
  logic [63:0]  pend_word_q;
  logic [3:0]   pend_n_q;
  logic [2:0]   oidx_q;

  comp_req_t req;
  logic [3:0] m_addr;
  logic c_busy, c_done;
  logic [511:0] c_h;

  logic in_acc;
  logic [3:0] n_eff;
  logic [63:0] w_mask;

  assign in_stall_o = (state_q != T_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == T_IDLE);

  always_comb begin
    n_eff = 4'd8;
    if (last_word_i && byte_count_i < 4'd8) n_eff = byte_count_i;
    for (int i = 0; i < 8; i++) w_mask[8*i +: 8] = (4'(i) < n_eff) ? 8'hff : 8'h00;
  end

  function automatic logic [511:0] init_h(input logic [6:0] l);
    logic [511:0] h;
    for (int i = 0; i < 8; i++) h[64*i +: 64] = IV[i];
    h[63:0] = h[63:0] ^ {39'd0, 1'b1, 7'd0, 1'b1, 9'd0, used_len(l)};
    return h;
  endfunction

  logic need_pre;
  assign need_pre = (n_eff != 4'd0) && (fill_q[7]);

  always_ff @(posedge clk_i) begin
    if (state_q == T_IDLE && in_acc && n_eff != 4'd0 && !fill_q[7])
      buf_mem[fill_q[6:3]] <= message_word_i & w_mask;
    else if (state_q == T_PRE && c_done)
      buf_mem[4'd0] <= pend_word_q;
    buf_rd_q <= buf_mem[m_addr];
  end

  assign req.start = (state_q == T_PRE || state_q == T_FINAL) && !c_busy && !c_done;
  assign req.final_blk = (state_q == T_FINAL);
  assign req.counter = (state_q == T_FINAL) ? cnt_q + {120'd0, fill_q} : cnt_q + 128'd128;
  assign req.fill = fill_q;

  b2b_compress u_comp (
    .clk_i, .rst_ni, .req_i(req), .h_i(h_q),
    .m_addr_o(m_addr), .m_data_i(buf_rd_q),
    .busy_o(c_busy), .done_o(c_done), .h_o(c_h)
  );

  logic [6:0] ul;
  logic [2:0] nwords_m1;
  logic [6:0] rem;
  assign ul = used_len(len_q);
  assign nwords_m1 = 3'((ul - 7'd1) >> 3);
  assign rem = ul - {1'b0, oidx_q, 3'b000};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: if (in_acc) begin
        if (need_pre) state_d = T_PRE;
        else if (last_word_i) state_d = T_FINAL;
      end
      T_PRE:   if (c_done) state_d = pend_last_q ? T_FINAL : T_IDLE;
      T_FINAL: if (c_done) state_d = T_OUT;
      T_OUT:   if (!out_stall_i && oidx_q == nwords_m1) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      len_q <= DigestReset;
      h_q <= init_h(DigestReset);
      cnt_q <= '0;
      fill_q <= '0;
      oidx_q <= '0;
      pend_last_q <= 1'b0;
      pend_word_q <= '0;
      pend_n_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= digest_bytes_i;
        h_q <= init_h(digest_bytes_i);
        cnt_q <= '0;
        fill_q <= '0;
      end else begin
        unique case (state_q)
          T_IDLE: if (in_acc) begin
            pend_last_q <= last_word_i;
            pend_word_q <= message_word_i & w_mask;
            pend_n_q <= n_eff;
            if (!need_pre) fill_q <= fill_q + {4'd0, n_eff};
          end
          T_PRE: if (c_done) begin
            h_q <= c_h;
            cnt_q <= cnt_q + 128'd128;
            fill_q <= {4'd0, pend_n_q};
          end
          T_FINAL: if (c_done) begin
            h_q <= c_h;
            oidx_q <= '0;
          end
          T_OUT: if (!out_stall_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == nwords_m1) begin
              h_q <= init_h(len_q);
              cnt_q <= '0;
              fill_q <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  logic [63:0] dmask;
  always_comb begin
    for (int i = 0; i < 8; i++) dmask[8*i +: 8] = (7'(i) < rem) ? 8'hff : 8'h00;
  end
  assign out_valid_o = (state_q == T_OUT);
  assign digest_word_o = h_q[64*oidx_q +: 64] & dmask;
  assign word_index_o = oidx_q;
  assign valid_bytes_o = (rem > 7'd8) ? 4'd8 : rem[3:0];
  assign last_result_o = (oidx_q == nwords_m1);
endmodule
`default_nettype wire

// ----- src/blake2b_hash_engine_unit_chk.sv -----
`default_nettype none
`include "blake2b_hash_engine_unit_macros.svh"
module blake2b_hash_engine_unit_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       cfg_ready_o,
  input wire logic [2:0] word_index_o,
  input wire logic [3:0] valid_bytes_o,
  input wire logic       last_result_o
);
  // no input taken while a digest is being shown
  `B2B_ASSERT_IMP(a_out_blocks_in, clk_i, rst_ni, !out_valid_o || in_stall_o)
  `B2B_ASSERT_IMP(a_vb_range, clk_i, rst_ni, !out_valid_o || (valid_bytes_o != 4'd0 && valid_bytes_o <= 4'd8))
  `B2B_ASSERT_IMP(a_cfg_idle, clk_i, rst_ni, !cfg_ready_o || !out_valid_o)
  // advance the index after a non-final word
  `B2B_ASSERT_NXT(a_idx_step, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_result_o, out_valid_o && word_index_o == $past(word_index_o) + 3'd1)
endmodule
bind blake2b_hash_engine_unit blake2b_hash_engine_unit_chk u_chk (.*);
`default_nettype wire
